// ===== src/ssl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants of the six-channel servo slew limiter.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int CHANNELS = 6;
  localparam int SLOTS    = 6;
  localparam int ANGLE_W  = 12;

  typedef logic [ANGLE_W-1:0] angle_t;

  localparam angle_t ANGLE_MAX  = 12'd2880;
  localparam angle_t ANGLE_MID  = 12'd1440;
  localparam angle_t STEP_RESET = 12'd16;
  localparam angle_t STEP_MIN   = 12'd1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_STEP   = 2'd0,
    REG_INVERT = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic   cmd;
    angle_t target_a;
    angle_t target_b;
    angle_t target_c;
    angle_t target_d;
    angle_t target_e;
    angle_t target_f;
  } ssl_in_t;

  typedef struct packed {
    angle_t drive_a;
    angle_t drive_b;
    angle_t drive_c;
    angle_t drive_d;
    angle_t drive_e;
    angle_t drive_f;
    logic   settled;
  } ssl_out_t;

  typedef struct packed {
    logic load;
    logic tick;
  } lane_ctl_t;

endpackage

// ===== src/six_channel_servo_slew_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_channel_servo_slew_limiter
// Six servo channels ramp toward loaded goal angles by a programmable step.
// ----------------------------------------------------------------------------
// Angles are 1/16 degree, 0 to 2880. A load item (cmd 0) stores six goals,
// saturated at 2880, and produces no result. A tick item (cmd 1) moves each
// channel one step toward its goal, snapping onto it when closer than a step,
// and produces one result in the next cycle: the six angles, mirrored per the
// invert mask, and settled when every channel was already on its goal. The
// six lanes run in parallel, so one item is taken every cycle while the
// output register is free or being drained. Register 0 is the step (0 reads
// as 1, values above 2880 as 2880), register 1 the invert mask. The
// configuration port is always ready.
// ----------------------------------------------------------------------------
module six_channel_servo_slew_limiter
  import ssl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ssl_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ssl_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  angle_t     cfg_data
);

  angle_t             step;
  logic   [SLOTS-1:0] invert_mask;
  logic               in_accept;
  logic               tick;
  lane_ctl_t          ctl;
  angle_t [SLOTS-1:0] targets;
  angle_t [SLOTS-1:0] drives;
  logic   [SLOTS-1:0] on_goal;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign tick      = in_accept && (in_data.cmd == CMD_TICK);
  assign ctl.load  = in_accept && (in_data.cmd == CMD_LOAD);
  assign ctl.tick  = tick;

  assign targets[0] = in_data.target_a;
  assign targets[1] = in_data.target_b;
  assign targets[2] = in_data.target_c;
  assign targets[3] = in_data.target_d;
  assign targets[4] = in_data.target_e;
  assign targets[5] = in_data.target_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_RESET;
      invert_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP: begin
          if (cfg_data == '0) begin
            step <= STEP_MIN;
          end else if (cfg_data > ANGLE_MAX) begin
            step <= ANGLE_MAX;
          end else begin
            step <= cfg_data;
          end
        end
        REG_INVERT: begin
          invert_mask <= cfg_data[SLOTS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    if (i < CHANNELS) begin : g_active
      ssl_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .target     (targets[i]),
        .step       (step),
        .invert     (invert_mask[i]),
        .drive_next (drives[i]),
        .match      (on_goal[i])
      );
    end else begin : g_idle
      assign drives[i]  = '0;
      assign on_goal[i] = 1'b1;
    end
  end

  ssl_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .drives    (drives),
    .on_goal   (on_goal),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assert property (@(posedge clk) disable iff (rst) tick |=> out_valid)
    else $error("tick item produced no result");
  assert property (@(posedge clk) disable iff (rst)
    (ctl.load && out_valid && out_ready) |=> !out_valid)
    else $error("load item produced a result");
  assert property (@(posedge clk) disable iff (rst)
    (step != '0) && (step <= ANGLE_MAX))
    else $error("step register out of range");

endmodule

// ===== src/ssl_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_lane
// One channel: goal and present angle, one slew step per tick, output mirror.
// ----------------------------------------------------------------------------
module ssl_lane
  import ssl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lane_ctl_t ctl,
  input  angle_t    target,
  input  angle_t    step,
  input  logic      invert,
  output angle_t    drive_next,
  output logic      match
);

  angle_t goal;
  angle_t present;
  angle_t present_next;
  angle_t gap_up;
  angle_t gap_down;

  assign match    = (present == goal);
  assign gap_up   = goal - present;
  assign gap_down = present - goal;

  always_comb begin
    if (match) begin
      present_next = present;
    end else if (goal > present) begin
      present_next = (gap_up < step) ? goal : present + step;
    end else begin
      present_next = (gap_down < step) ? goal : present - step;
    end
  end

  assign drive_next = invert ? ANGLE_MAX - present_next : present_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal    <= ANGLE_MID;
      present <= ANGLE_MID;
    end else begin
      if (ctl.load) begin
        goal <= (target > ANGLE_MAX) ? ANGLE_MAX : target;
      end
      if (ctl.tick) begin
        present <= present_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) present <= ANGLE_MAX)
    else $error("present angle out of range");
  assert property (@(posedge clk) disable iff (rst) goal <= ANGLE_MAX)
    else $error("goal angle out of range");
  assert property (@(posedge clk) disable iff (rst)
    (ctl.tick && !ctl.load && !match) |=> (present != $past(present)))
    else $error("unsettled lane did not move on tick");

endmodule

// ===== src/ssl_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_merge
// Combine lane results into one item and hold it in the output register.
// ----------------------------------------------------------------------------
module ssl_merge
  import ssl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  angle_t [SLOTS-1:0]   drives,
  input  logic   [SLOTS-1:0]   on_goal,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssl_out_t             out_data
);

  ssl_out_t item_next;

  always_comb begin
    item_next.drive_a = drives[0];
    item_next.drive_b = drives[1];
    item_next.drive_c = drives[2];
    item_next.drive_d = drives[3];
    item_next.drive_e = drives[4];
    item_next.drive_f = drives[5];
    item_next.settled = &on_goal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_data <= item_next;
    end
  end

endmodule
